// File: rtl/lrr_pkg.sv
// shared types and constants for the lcg range random block
package lrr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned DIV_W  = 48;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned FRAC_W = 16;

  // request codes
  localparam logic [1:0] REQ_SEED = 2'd0;
  localparam logic [1:0] REQ_INT  = 2'd1;
  localparam logic [1:0] REQ_FRAC = 2'd2;

  // lcg step constants
  localparam logic [WORD_W-1:0] LCG_MUL = 32'd214013;
  localparam logic [WORD_W-1:0] LCG_ADD = 32'd2531011;

  // q16.16 fraction scale divisor
  localparam logic [FRAC_W-1:0] FRAC_DIVISOR = 16'd65535;

  // divider and fold pass lengths
  localparam logic [CNT_W-1:0] DIV_CNT_INT  = 6'd32;
  localparam logic [CNT_W-1:0] DIV_CNT_FRAC = 6'd4;

  typedef struct packed {
    logic load;
    logic step;
    logic prep;
    logic iter;
    logic finish;
    logic out_load;
  } lrr_cmd_t;

  typedef struct packed {
    logic draw;
    logic skip;
    logic div_last;
  } lrr_sts_t;

endpackage

// File: rtl/lrr_req_if.sv
// request channel: valid/ready with the request fields
interface lrr_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         req_type;
  logic                               use_self;
  logic [lrr_pkg::WORD_W-1:0]         seed_value;
  logic [lrr_pkg::WORD_W-1:0]         time_value;
  logic signed [lrr_pkg::WORD_W-1:0]  range_low;
  logic signed [lrr_pkg::WORD_W-1:0]  range_high;

  modport source (
    output valid, req_type, use_self, seed_value, time_value, range_low, range_high,
    input  ready
  );
  modport sink (
    input  valid, req_type, use_self, seed_value, time_value, range_low, range_high,
    output ready
  );
endinterface

// File: rtl/lrr_rsp_if.sv
// result channel: valid/ready with the drawn value
interface lrr_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [lrr_pkg::WORD_W-1:0]  value;

  modport source (
    output valid, value,
    input  ready
  );
  modport sink (
    input  valid, value,
    output ready
  );
endinterface

// File: rtl/lrr_ctrl.sv
// controller fsm: sequences step, divider pass and result beat
module lrr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lrr_pkg::lrr_sts_t sts,
  output lrr_pkg::lrr_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_STEP = 6'b000010,
    ST_PREP = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = sts.draw ? ST_PREP : ST_OUT;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sts.skip ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cmd.iter = 1'b1;
        if (sts.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/lrr_datapath.sv
// datapath: seed registers, lcg step, range mapping, radix-2 divider and 65535 fold
module lrr_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  lrr_pkg::lrr_cmd_t                  cmd,
  output lrr_pkg::lrr_sts_t                  sts,
  input  logic [1:0]                         req_type,
  input  logic                               use_self,
  input  logic [lrr_pkg::WORD_W-1:0]         seed_value,
  input  logic [lrr_pkg::WORD_W-1:0]         time_value,
  input  logic signed [lrr_pkg::WORD_W-1:0]  range_low,
  input  logic signed [lrr_pkg::WORD_W-1:0]  range_high,
  output logic signed [lrr_pkg::WORD_W-1:0]  value
);

  // latched request
  logic [1:0]                 kind;
  logic                       pick_self;
  logic [lrr_pkg::WORD_W-1:0] seed_in;
  logic [lrr_pkg::WORD_W-1:0] time_in;
  logic [lrr_pkg::WORD_W-1:0] lo;
  logic [lrr_pkg::WORD_W-1:0] hi;

  // generator state
  logic [lrr_pkg::WORD_W-1:0] main_seed;
  logic [lrr_pkg::WORD_W-1:0] self_seed;
  logic [lrr_pkg::WORD_W-1:0] s;

  // divider and result
  logic [lrr_pkg::DIV_W-1:0]  dq;
  logic [lrr_pkg::WORD_W-1:0] rem;
  logic [lrr_pkg::WORD_W-1:0] dv;
  logic [lrr_pkg::CNT_W-1:0]  cnt;
  logic                       neg;
  logic [lrr_pkg::WORD_W-1:0] res;

  logic [lrr_pkg::WORD_W-1:0] sel_seed;
  logic [lrr_pkg::WORD_W-1:0] step_val;
  logic [lrr_pkg::WORD_W-1:0] span;
  logic [lrr_pkg::WORD_W-1:0] mixed;
  logic [lrr_pkg::WORD_W:0]   diff;
  logic [lrr_pkg::WORD_W:0]   mag;
  logic [lrr_pkg::DIV_W-1:0]  prod;
  logic [lrr_pkg::WORD_W:0]   trial;
  logic [lrr_pkg::WORD_W:0]   trial_sub;
  logic                       trial_ge;
  logic [lrr_pkg::WORD_W-1:0] fin_val;

  assign sel_seed = pick_self ? self_seed : main_seed;
  assign step_val = sel_seed * lrr_pkg::LCG_MUL + lrr_pkg::LCG_ADD;

  assign span  = hi - lo + 32'd1;
  assign mixed = s ^ (s >> 15);
  assign diff  = {hi[lrr_pkg::WORD_W-1], hi} - {lo[lrr_pkg::WORD_W-1], lo};
  assign mag   = diff[lrr_pkg::WORD_W] ? (33'd0 - diff) : diff;
  assign prod  = lrr_pkg::DIV_W'(s[31:16]) * lrr_pkg::DIV_W'(mag[lrr_pkg::WORD_W-1:0]);

  // one restoring step per cycle
  assign trial     = {rem, dq[lrr_pkg::DIV_W-1]};
  assign trial_sub = trial - {1'b0, dv};
  assign trial_ge  = (trial >= {1'b0, dv});

  assign fin_val = (kind == lrr_pkg::REQ_INT) ? (lo + rem) :
                   (neg ? (lo - rem) : (lo + rem));

  assign sts.draw     = (kind == lrr_pkg::REQ_INT) || (kind == lrr_pkg::REQ_FRAC);
  assign sts.skip     = (kind == lrr_pkg::REQ_INT) ? (span == '0) : (lo == hi);
  assign sts.div_last = (cnt == 6'd1);

  // seed registers are architectural state and reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      main_seed <= '0;
      self_seed <= '0;
    end else if (cmd.step) begin
      case (kind)
        lrr_pkg::REQ_SEED: begin
          if (seed_in == '0) begin
            main_seed <= time_in;
            self_seed <= time_in;
          end else begin
            main_seed <= seed_in;
          end
        end
        lrr_pkg::REQ_INT, lrr_pkg::REQ_FRAC: begin
          if (pick_self) begin
            self_seed <= step_val;
          end else begin
            main_seed <= step_val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind      <= req_type;
      pick_self <= use_self;
      seed_in   <= seed_value;
      time_in   <= time_value;
      lo        <= range_low;
      hi        <= range_high;
    end

    if (cmd.step) begin
      s <= step_val;
      case (kind)
        lrr_pkg::REQ_SEED: begin
          res <= (seed_in == '0) ? time_in : seed_in;
        end
        default: begin
          res <= '0;
        end
      endcase
    end

    if (cmd.prep) begin
      rem <= '0;
      neg <= diff[lrr_pkg::WORD_W];
      res <= lo;
      if (kind == lrr_pkg::REQ_INT) begin
        dv  <= span;
        dq  <= {mixed, 16'h0000};
        cnt <= lrr_pkg::DIV_CNT_INT;
      end else begin
        dq  <= prod;
        cnt <= lrr_pkg::DIV_CNT_FRAC;
      end
    end

    if (cmd.iter) begin
      cnt <= cnt - 6'd1;
      if (kind == lrr_pkg::REQ_INT) begin
        rem <= trial_ge ? trial_sub[lrr_pkg::WORD_W-1:0] : trial[lrr_pkg::WORD_W-1:0];
        dq  <= {dq[lrr_pkg::DIV_W-2:0], trial_ge};
      end else if (dq[lrr_pkg::DIV_W-1:lrr_pkg::FRAC_W] != '0) begin
        // 2^16 is 1 mod 65535: move the high part into the quotient and fold it back
        rem <= rem + dq[lrr_pkg::DIV_W-1:lrr_pkg::FRAC_W];
        dq  <= lrr_pkg::DIV_W'(dq[lrr_pkg::DIV_W-1:lrr_pkg::FRAC_W]) +
               lrr_pkg::DIV_W'(dq[lrr_pkg::FRAC_W-1:0]);
      end else if (dq[lrr_pkg::FRAC_W-1:0] == lrr_pkg::FRAC_DIVISOR) begin
        rem <= rem + 32'd1;
        dq  <= '0;
      end
    end

    if (cmd.finish) begin
      res <= fin_val;
    end

    if (cmd.out_load) begin
      value <= res;
    end
  end

endmodule

// File: rtl/lcg_range_random.sv
// top level: two lcg generators with integer and q16.16 range draws
//
// req channel carries one request per beat: seed load, integer draw or
// q16.16 fraction draw; rsp channel returns exactly one value per request.
// the block handles one request at a time: req.ready is high only while
// the controller is idle.
// seed loads and unused codes go from the step straight to the result,
// and a draw with an empty range skips the divider. an integer draw
// runs the radix-2 divider, which retires one quotient bit per cycle
// (32 bits for the modulo by the span); the divide by 65535 folds the
// high part of the product back into its low 16 bits.
// a new request is taken in the cycle after the result is loaded.
// the result sits in an output register; the next request is taken while
// it waits, and a stalled receiver only holds the next result back.
// synchronous reset clears both generators to zero, drops rsp.valid and
// returns the controller to idle.
module lcg_range_random (
  input  logic      clk,
  input  logic      rst,
  lrr_req_if.sink   req,
  lrr_rsp_if.source rsp
);

  lrr_pkg::lrr_cmd_t cmd;
  lrr_pkg::lrr_sts_t sts;

  lrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req.req_type),
    .use_self   (req.use_self),
    .seed_value (req.seed_value),
    .time_value (req.time_value),
    .range_low  (req.range_low),
    .range_high (req.range_high),
    .value      (rsp.value)
  );

endmodule

// File: tb/sv/testbench.sv
// testbench for lcg_range_random: lcg model, seed loads, integer and q16.16 range draws
module testbench;

  localparam logic [1:0] REQ_SEED   = lrr_pkg::REQ_SEED;
  localparam logic [1:0] REQ_INT    = lrr_pkg::REQ_INT;
  localparam logic [1:0] REQ_FRAC   = lrr_pkg::REQ_FRAC;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1250;

  typedef struct {
    logic [1:0]         req_type;
    logic               use_self;
    logic [31:0]        seed_value;
    logic [31:0]        time_value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } draw_req_t;

  class lcg_draw_board;
    logic [31:0] gen_primary;
    logic [31:0] gen_alt;
    logic [31:0] expected_values[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned n_seed, n_int, n_frac, n_unused;

    function new();
      gen_primary = '0;
      gen_alt     = '0;
    endfunction

    function logic [31:0] step_lcg(logic pick_alt);
      if (pick_alt) begin
        gen_alt = gen_alt * lrr_pkg::LCG_MUL + lrr_pkg::LCG_ADD;
        return gen_alt;
      end
      gen_primary = gen_primary * lrr_pkg::LCG_MUL + lrr_pkg::LCG_ADD;
      return gen_primary;
    endfunction

    function logic [31:0] predict_draw(draw_req_t r);
      logic [31:0] s, span, mixed, lo_u, hi_u;
      longint lo, hi, prod;
      lo_u = r.range_low;
      hi_u = r.range_high;
      case (r.req_type)
        REQ_SEED: begin
          if (r.seed_value == '0) begin
            gen_primary = r.time_value;
            gen_alt     = r.time_value;
          end else begin
            gen_primary = r.seed_value;
          end
          return gen_primary;
        end
        REQ_INT: begin
          s    = step_lcg(r.use_self);
          span = hi_u - lo_u + 32'd1;
          if (span == '0) return lo_u;
          mixed = s ^ (s >> 15);
          return lo_u + (mixed % span);
        end
        REQ_FRAC: begin
          s  = step_lcg(r.use_self);
          lo = r.range_low;
          hi = r.range_high;
          if (lo == hi) return lo_u;
          // top 16 bits of the state scale the exact 33-bit difference
          prod = longint'(s[31:16]) * (hi - lo);
          return 32'(lo + prod / longint'(lrr_pkg::FRAC_DIVISOR));
        end
        default: return '0;
      endcase
    endfunction

    function void note_request(draw_req_t r);
      case (r.req_type)
        REQ_SEED: n_seed++;
        REQ_INT:  n_int++;
        REQ_FRAC: n_frac++;
        default:  n_unused++;
      endcase
      expected_values.push_back(predict_draw(r));
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_value(logic [31:0] got);
      logic [31:0] want;
      checked++;
      if (expected_values.size() == 0) begin
        report_mismatch($sformatf("value %h with no request outstanding", got));
        return;
      end
      want = expected_values.pop_front();
      if (got !== want)
        report_mismatch($sformatf("result %0d value %h, want %h", checked, got, want));
    endtask
  endclass

  logic clk;
  logic rst;

  lrr_req_if req_ch ();
  lrr_rsp_if rsp_ch ();

  lcg_range_random u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lcg_draw_board board;

  bit          hold_kick;
  int unsigned hold_left;
  int unsigned pattern_left;
  int unsigned pattern_kind;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver: check each result beat, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      board.check_value(rsp_ch.value);
    if (hold_kick) begin
      hold_kick = 1'b0;
      hold_left = 300;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_kind = $urandom_range(0, 3);
        pattern_left = $urandom_range(20, 200);
      end
      pattern_left--;
      case (pattern_kind)
        0:       rsp_ch.ready <= 1'b1;
        1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
        2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic draw_req_t mk_req(logic [1:0] t, logic sel, logic [31:0] sd,
                                       logic [31:0] tm, logic [31:0] lo, logic [31:0] hi);
    draw_req_t r;
    r.req_type   = t;
    r.use_self   = sel;
    r.seed_value = sd;
    r.time_value = tm;
    r.range_low  = lo;
    r.range_high = hi;
    return r;
  endfunction

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic void pick_bounds(output logic signed [31:0] lo,
                                      output logic signed [31:0] hi);
    case ($urandom_range(0, 5))
      0: begin
        lo = $urandom;
        hi = lo + 32'($urandom_range(0, 1000));
      end
      1: begin
        lo = $urandom;
        hi = $urandom;
      end
      2: begin
        lo = $urandom;
        hi = lo;
      end
      3: begin
        lo = extreme_word();
        hi = extreme_word();
      end
      4: begin
        // span wraps to zero for integer draws
        lo = $urandom;
        hi = lo - 32'sd1;
      end
      default: begin
        // a few units either side of zero in q16.16
        lo = 32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
        hi = lo + 32'($urandom_range(0, 32'h0002_0000));
      end
    endcase
  endfunction

  function automatic draw_req_t rand_req();
    draw_req_t   r;
    int unsigned pick;
    pick         = $urandom_range(0, 99);
    r.use_self   = 1'($urandom_range(0, 1));
    r.seed_value = $urandom;
    r.time_value = $urandom;
    pick_bounds(r.range_low, r.range_high);
    if (pick < 10) begin
      r.req_type = REQ_SEED;
      if ($urandom_range(0, 2) == 0) r.seed_value = '0;
    end else if (pick < 54) begin
      r.req_type = REQ_INT;
    end else if (pick < 97) begin
      r.req_type = REQ_FRAC;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic send_req(draw_req_t r);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.req_type;
    req_ch.use_self   <= r.use_self;
    req_ch.seed_value <= r.seed_value;
    req_ch.time_value <= r.time_value;
    req_ch.range_low  <= r.range_low;
    req_ch.range_high <= r.range_high;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    board.note_request(r);
  endtask

  task automatic pause_sender(int unsigned n);
    if (n != 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_values.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    draw_req_t list[$];
    list.push_back(mk_req(REQ_INT,  1'b0, 32'h1, 32'h0, 32'd0, 32'd9));
    list.push_back(mk_req(REQ_FRAC, 1'b1, 32'h1, 32'h0, 32'd0, 32'h0001_0000));
    list.push_back(mk_req(REQ_INT,  1'b1, 32'h1, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF));
    list.push_back(mk_req(REQ_SEED, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'd0, 32'd0));
    list.push_back(mk_req(REQ_INT,  1'b0, 32'h0, 32'h0, 32'd5, 32'd5));
    list.push_back(mk_req(REQ_INT,  1'b0, 32'h0, 32'h0, 32'd10, 32'd3));
    list.push_back(mk_req(REQ_INT,  1'b0, 32'h0, 32'h0, 32'd0, 32'h7FFF_FFFE));
    list.push_back(mk_req(REQ_INT,  1'b1, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000));
    list.push_back(mk_req(REQ_FRAC, 1'b0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF));
    list.push_back(mk_req(REQ_FRAC, 1'b1, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000));
    list.push_back(mk_req(REQ_FRAC, 1'b0, 32'h0, 32'h0, 32'h1234_0000, 32'h1234_0000));
    list.push_back(mk_req(REQ_FRAC, 1'b1, 32'h0, 32'h0, 32'hFFFF_8000, 32'h0000_8000));
    list.push_back(mk_req(REQ_SEED, 1'b1, 32'h1234_5678, 32'hDEAD_BEEF, 32'd0, 32'd0));
    list.push_back(mk_req(REQ_INT,  1'b0, 32'h0, 32'h0, -32'sd100, 32'sd100));
    list.push_back(mk_req(REQ_SEED, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'd0, 32'd0));
    list.push_back(mk_req(REQ_FRAC, 1'b0, 32'h0, 32'h0, 32'd0, 32'd1));
    list.push_back(mk_req(REQ_UNUSED, 1'b1, $urandom, $urandom, $urandom, $urandom));
    list.push_back(mk_req(REQ_SEED, 1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    list.push_back(mk_req(REQ_INT,  1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'd0));
    list.push_back(mk_req(REQ_FRAC, 1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'd0));
    list.push_back(mk_req(REQ_SEED, 1'b1, 32'h8000_0000, $urandom, 32'd0, 32'd0));
    list.push_back(mk_req(REQ_INT,  1'b0, 32'h0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF));
    list.push_back(mk_req(REQ_UNUSED, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
    foreach (list[i]) begin
      send_req(list[i]);
      pause_sender($urandom_range(0, 3));
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    bit          hold_done;
    bit          drain_done;
    board = new();
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_SEED;
    req_ch.use_self    = 1'b0;
    req_ch.seed_value  = '0;
    req_ch.time_value  = '0;
    req_ch.range_low   = '0;
    req_ch.range_high  = '0;
    rsp_ch.ready       = 1'b0;
    hold_kick          = 1'b0;
    hold_left          = 0;
    pattern_left       = 0;
    sent               = 0;
    hold_done          = 1'b0;
    drain_done         = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    wait_drained();

    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      // long receiver hold while the sender keeps pushing
      if (sent >= 400 && !hold_done) begin
        hold_done = 1'b1;
        hold_kick = 1'b1;
        burst     = 8;
      end
      if (sent >= 800 && !drain_done) begin
        drain_done = 1'b1;
        wait_drained();
      end
      repeat (burst) begin
        send_req(rand_req());
        sent++;
      end
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 10);
        default: gap = $urandom_range(11, 60);
      endcase
      pause_sender(gap);
    end

    wait_drained();
    repeat (80) @(posedge clk);

    $display("covered %0d requests: %0d seed loads, %0d integer draws,",
             board.n_seed + board.n_int + board.n_frac + board.n_unused,
             board.n_seed, board.n_int);
    $display("%0d fraction draws, %0d unused codes; %0d result beats checked, %0d mismatches",
             board.n_frac, board.n_unused, board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results still outstanding", board.expected_values.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/lrr_pkg.sv
rtl/lrr_req_if.sv
rtl/lrr_rsp_if.sv
rtl/lrr_ctrl.sv
rtl/lrr_datapath.sv
rtl/lcg_range_random.sv
tb/sv/testbench.sv
